// ===== rtl/swct_pkg.sv =====
// ----------------------------------------------------------------------------
// Sorted word count table package
// Command and status codes, the cell control bundle and shared helpers.
// ----------------------------------------------------------------------------
package swct_pkg;

  localparam int KEY_W   = 64;
  localparam int COUNT_W = 16;
  localparam int RANK_W  = 6;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_RANK   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_RANK = 2'd2
  } status_e;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic cmp_en;
    logic ins_en;
    logic inc_en;
    cmd_e cmd;
  } ctrl_t;

  function automatic logic [COUNT_W-1:0] count_inc(input logic [COUNT_W-1:0] c);
    return (c == COUNT_MAX) ? c : c + COUNT_W'(1);
  endfunction

endpackage

// ===== rtl/swct_cell.sv =====
// ----------------------------------------------------------------------------
// Table cell
// Holds one sorted entry, compares it with the request key and shifts toward
// the tail when a new word is inserted in front of it.
// ----------------------------------------------------------------------------
module swct_cell #(
  parameter int ENTRIES    = 64,
  parameter int WORD_CHARS = 8,
  parameter int IDX        = 0
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  swct_pkg::ctrl_t                           ctrl_i,
  input  logic [$clog2(ENTRIES+1)-1:0]              used_i,
  input  logic [8*WORD_CHARS-1:0]                   key_i,
  input  logic [swct_pkg::RANK_W-1:0]               rank_i,
  input  logic [8*WORD_CHARS-1:0]                   prev_key_i,
  input  logic [swct_pkg::COUNT_W-1:0]              prev_count_i,
  input  logic                                      prev_lt_i,
  output logic [8*WORD_CHARS-1:0]                   key_o,
  output logic [swct_pkg::COUNT_W-1:0]              count_o,
  output logic                                      lt_o,
  output logic [8*WORD_CHARS+swct_pkg::COUNT_W:0]   leaf_o
);
  import swct_pkg::*;

  localparam int KW = 8 * WORD_CHARS;
  localparam int UW = $clog2(ENTRIES + 1);
  localparam int IW = $clog2(ENTRIES);
  localparam int CW = (IW > RANK_W) ? IW : RANK_W;
  localparam int NW = 1 + COUNT_W + KW;

  logic [KW-1:0]      key_q;
  logic [COUNT_W-1:0] count_q;
  logic               lt_q, lt_d;
  logic               eq_q, eq_d;
  logic [NW-1:0]      leaf_q, leaf_d;
  logic               valid;
  logic               hit;

  always_comb begin
    valid = used_i > UW'(IDX);
    lt_d  = valid && (key_q < key_i);
    eq_d  = valid && (key_q == key_i);
    unique case (ctrl_i.cmd)
      CMD_INSERT, CMD_LOOKUP: hit = eq_d;
      CMD_RANK:               hit = valid && (CW'(rank_i) == CW'(IDX));
      default:                hit = 1'b0;
    endcase
    leaf_d = hit ? {1'b1, count_q, key_q} : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      lt_q <= lt_d;
      eq_q <= eq_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmp_en) begin
      leaf_q <= leaf_d;
    end
    // The first cell not below the key takes the new word; every cell after
    // it takes its neighbor's entry.
    if (ctrl_i.ins_en) begin
      if (!lt_q && prev_lt_i) begin
        key_q   <= key_i;
        count_q <= COUNT_W'(1);
      end else if (!prev_lt_i) begin
        key_q   <= prev_key_i;
        count_q <= prev_count_i;
      end
    end else if (ctrl_i.inc_en && eq_q) begin
      count_q <= count_inc(count_q);
    end
  end

  assign key_o   = key_q;
  assign count_o = count_q;
  assign lt_o    = lt_q;
  assign leaf_o  = leaf_q;

endmodule

// ===== rtl/swct_tree.sv =====
// ----------------------------------------------------------------------------
// Result collection tree
// Registered OR tree that gathers the single selected cell onto one node.
// ----------------------------------------------------------------------------
module swct_tree #(
  parameter int LEAVES = 64,
  parameter int NW     = 81
) (
  input  logic          clk_i,
  input  logic [NW-1:0] leaf_i [LEAVES],
  output logic [NW-1:0] root_o
);
  localparam int LEVELS = $clog2(LEAVES);
  localparam int POW    = 1 << LEVELS;
  localparam int NODES  = POW - 1;

  logic [NW-1:0] node_q [NODES];

  for (genvar n = 0; n < NODES; n++) begin : g_node
    localparam int LC = 2 * n + 1;
    localparam int RC = 2 * n + 2;
    logic [NW-1:0] left, right;

    if (LC < NODES) begin : g_l_int
      assign left = node_q[LC];
    end else if (LC - NODES < LEAVES) begin : g_l_leaf
      assign left = leaf_i[LC - NODES];
    end else begin : g_l_pad
      assign left = '0;
    end

    if (RC < NODES) begin : g_r_int
      assign right = node_q[RC];
    end else if (RC - NODES < LEAVES) begin : g_r_leaf
      assign right = leaf_i[RC - NODES];
    end else begin : g_r_pad
      assign right = '0;
    end

    always_ff @(posedge clk_i) begin
      node_q[n] <= left | right;
    end
  end

  assign root_o = node_q[0];

endmodule

// ===== rtl/sorted_word_count_table.sv =====
// ----------------------------------------------------------------------------
// Sorted word count table
// Counts distinct words in ascending order; insert, look up, read by rank.
// ----------------------------------------------------------------------------
// One command is taken while busy_o is low. Once accepted it passes through
// the compare state, in which every cell compares its entry with the key,
// the tree state, which steps once per level of the registered tree that
// gathers the matching cell, and the done state, in which the result is shown
// and the cells update. A new command may be accepted in the done state. The
// result is on the output ports for exactly one cycle, marked by done_o, and
// the receiver cannot hold it off.
module sorted_word_count_table #(
  parameter int ENTRIES    = 64,
  parameter int WORD_CHARS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [1:0]                      cmd_i,
  input  logic [swct_pkg::KEY_W-1:0]      word_key_i,
  input  logic [swct_pkg::RANK_W-1:0]     rank_i,
  output logic                            done_o,
  output logic [swct_pkg::COUNT_W-1:0]    count_o,
  output logic                            found_o,
  output logic [1:0]                      status_o,
  output logic [swct_pkg::KEY_W-1:0]      word_out_o
);
  import swct_pkg::*;

  localparam int KW     = 8 * WORD_CHARS;
  localparam int UW     = $clog2(ENTRIES + 1);
  localparam int LEVELS = $clog2(ENTRIES);
  localparam int LCW    = $clog2(LEVELS + 1);
  localparam int NW     = 1 + COUNT_W + KW;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CMP  = 4'b0010,
    S_TREE = 4'b0100,
    S_DONE = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  cmd_e              cmd_q;
  logic [KW-1:0]     key_q;
  logic [RANK_W-1:0] rank_q;
  logic [UW-1:0]     used_q;
  logic [LCW-1:0]    lvl_q;
  logic              accept;
  logic              full;
  ctrl_t             ctrl;

  logic [KW-1:0]      cell_key [ENTRIES];
  logic [COUNT_W-1:0] cell_cnt [ENTRIES];
  logic               cell_lt  [ENTRIES];
  logic [NW-1:0]      leaf     [ENTRIES];
  logic [NW-1:0]      root;
  logic               root_hit;
  logic [COUNT_W-1:0] root_count;
  logic [KW-1:0]      root_key;

  assign busy_o = !(state_q == S_IDLE || state_q == S_DONE);
  assign accept = start_i && !busy_o;
  assign full   = used_q == UW'(ENTRIES);

  always_comb begin
    unique case (state_q)
      S_IDLE:  state_d = accept ? S_CMP : S_IDLE;
      S_CMP:   state_d = S_TREE;
      S_TREE:  state_d = (lvl_q == '0) ? S_DONE : S_TREE;
      S_DONE:  state_d = accept ? S_CMP : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      lvl_q   <= '0;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CMP) begin
        lvl_q <= LCW'(LEVELS - 1);
      end else if (state_q == S_TREE) begin
        lvl_q <= lvl_q - LCW'(1);
      end
      if (ctrl.ins_en) begin
        used_q <= used_q + UW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= cmd_e'(cmd_i);
      key_q  <= word_key_i[KEY_W-1 -: KW];
      rank_q <= rank_i;
    end
  end

  assign root_hit   = root[NW-1];
  assign root_count = root[NW-2 -: COUNT_W];
  assign root_key   = root[KW-1:0];

  always_comb begin
    ctrl.cmp_en = state_q == S_CMP;
    ctrl.ins_en = 1'b0;
    ctrl.inc_en = 1'b0;
    ctrl.cmd    = cmd_q;
    done_o      = state_q == S_DONE;
    count_o     = '0;
    found_o     = 1'b0;
    status_o    = ST_OK;
    word_out_o  = '0;
    if (state_q == S_DONE) begin
      unique case (cmd_q)
        CMD_INSERT: begin
          priority if (root_hit) begin
            ctrl.inc_en = 1'b1;
            count_o     = count_inc(root_count);
            found_o     = 1'b1;
          end else if (full) begin
            status_o = ST_FULL;
          end else begin
            ctrl.ins_en = 1'b1;
            count_o     = COUNT_W'(1);
          end
        end
        CMD_LOOKUP: begin
          count_o = root_count;
          found_o = root_hit;
        end
        CMD_RANK: begin
          count_o    = root_count;
          found_o    = root_hit;
          word_out_o = KEY_W'(root_key) << (KEY_W - KW);
          status_o   = root_hit ? ST_OK : ST_RANK;
        end
        default: begin
        end
      endcase
    end
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    logic [KW-1:0]      prev_key;
    logic [COUNT_W-1:0] prev_count;
    logic               prev_lt;

    // Nothing stands in front of the head cell, so it never takes a shift.
    if (i == 0) begin : g_head
      assign prev_key   = key_q;
      assign prev_count = '0;
      assign prev_lt    = 1'b1;
    end else begin : g_link
      assign prev_key   = cell_key[i-1];
      assign prev_count = cell_cnt[i-1];
      assign prev_lt    = cell_lt[i-1];
    end

    swct_cell #(
      .ENTRIES   (ENTRIES),
      .WORD_CHARS(WORD_CHARS),
      .IDX       (i)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .used_i      (used_q),
      .key_i       (key_q),
      .rank_i      (rank_q),
      .prev_key_i  (prev_key),
      .prev_count_i(prev_count),
      .prev_lt_i   (prev_lt),
      .key_o       (cell_key[i]),
      .count_o     (cell_cnt[i]),
      .lt_o        (cell_lt[i]),
      .leaf_o      (leaf[i])
    );
  end

  swct_tree #(
    .LEAVES(ENTRIES),
    .NW    (NW)
  ) u_tree (
    .clk_i (clk_i),
    .leaf_i(leaf),
    .root_o(root)
  );

endmodule

// ===== rtl/swct_checker.sv =====
// ----------------------------------------------------------------------------
// Sorted word count table checker
// Port-level properties of the request sequencing and the result fields.
// ----------------------------------------------------------------------------
module swct_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input logic [1:0]                   cmd_i,
  input logic [swct_pkg::KEY_W-1:0]   word_key_i,
  input logic [swct_pkg::RANK_W-1:0]  rank_i,
  input logic                         done_o,
  input logic [swct_pkg::COUNT_W-1:0] count_o,
  input logic                         found_o,
  input logic [1:0]                   status_o,
  input logic [swct_pkg::KEY_W-1:0]   word_out_o
);
  import swct_pkg::*;

  // An accepted request always occupies the block in the next cycle.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted request did not make the block busy");

  // A result only follows a cycle of work.
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result strobe without preceding work");

  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && found_o) |-> (status_o == ST_OK))
    else $error("found result with an error status");

  a_rank_miss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_RANK) |-> (!found_o && count_o == '0 && word_out_o == '0))
    else $error("rank miss carries data");

  a_word_needs_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && word_out_o != '0) |-> found_o)
    else $error("word returned without a hit");

endmodule

bind sorted_word_count_table swct_checker u_swct_checker (.*);
